// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the FIFO cache directory.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int SLOTS        = 8;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TAG_W        = 16;
    localparam int SLOT_FIELD_W = 3;

    typedef logic [TAG_W-1:0]        tag_t;
    typedef logic [SLOT_W-1:0]       slot_idx_t;
    typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

    localparam slot_idx_t LAST_IDX = slot_idx_t'(SLOTS - 1);

    localparam logic MODE_REQ   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELIVER
    } seq_state_t;

    // tag memory access from the sequencer
    typedef struct packed {
        logic      re;
        slot_idx_t raddr;
        logic      we;
        slot_idx_t waddr;
        tag_t      wdata;
    } ram_req_t;

    // finished result handed to the output stage
    typedef struct packed {
        logic        valid;
        slot_field_t slot;
        logic        hit;
    } res_t;

    function automatic slot_field_t to_slot_field(input slot_idx_t idx);
        logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, idx};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/fcd_tag_ram.sv =====
// ----------------------------------------------------------------------------
// fcd_tag_ram
// Slot tag store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcd_tag_ram (
    input  logic             clk,
    input  fcd_pkg::ram_req_t req,
    output fcd_pkg::tag_t    rdata
);
    import fcd_pkg::*;

    tag_t mem [SLOTS];
    tag_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fcd_seq.sv =====
// ----------------------------------------------------------------------------
// fcd_seq
// Scan sequencer: walks the tag memory one slot a cycle, keeps valid bits
// and the round-robin victim pointer, and fills a slot on a miss.
// ----------------------------------------------------------------------------
module fcd_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  fcd_pkg::tag_t     item_number,
    output fcd_pkg::ram_req_t ram_req,
    input  fcd_pkg::tag_t     ram_rdata,
    output fcd_pkg::res_t     res,
    input  logic              res_take
);
    import fcd_pkg::*;

    seq_state_t        state_reg, state_next;
    tag_t              item_reg, item_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    slot_idx_t         victim_reg, victim_next;
    slot_idx_t         rd_idx_reg, rd_idx_next;
    logic              rd_done_reg, rd_done_next;
    logic              cmp_pend_reg, cmp_pend_next;
    slot_idx_t         cmp_idx_reg, cmp_idx_next;
    slot_idx_t         res_slot_reg, res_slot_next;
    logic              res_hit_reg, res_hit_next;

    logic match;
    logic miss;

    // read data of the previous cycle belongs to cmp_idx_reg
    assign match = cmp_pend_reg && valid_reg[cmp_idx_reg] && (ram_rdata == item_reg);
    assign miss  = cmp_pend_reg && (cmp_idx_reg == LAST_IDX) && !match;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (mode == MODE_REQ))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match || miss)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next     = item_reg;
        valid_next    = valid_reg;
        victim_next   = victim_reg;
        rd_idx_next   = rd_idx_reg;
        rd_done_next  = rd_done_reg;
        cmp_pend_next = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        res_slot_next = res_slot_reg;
        res_hit_next  = res_hit_reg;
        ram_req       = '0;
        in_ready      = 1'b0;
        res           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode == MODE_CLEAR)
                    begin
                        valid_next  = '0;
                        victim_next = '0;
                    end
                    else
                    begin
                        item_next    = item_number;
                        rd_idx_next  = '0;
                        rd_done_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_req.re    = !rd_done_reg;
                ram_req.raddr = rd_idx_reg;
                cmp_pend_next = !rd_done_reg;
                cmp_idx_next  = rd_idx_reg;
                if (!rd_done_reg)
                begin
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (match)
                begin
                    cmp_pend_next = 1'b0;
                    res_slot_next = cmp_idx_reg;
                    res_hit_next  = 1'b1;
                end
                else if (miss)
                begin
                    ram_req.we              = 1'b1;
                    ram_req.waddr           = victim_reg;
                    ram_req.wdata           = item_reg;
                    valid_next[victim_reg]  = 1'b1;
                    victim_next = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
                    res_slot_next = victim_reg;
                    res_hit_next  = 1'b0;
                end
            end
            ST_DELIVER:
            begin
                res.valid = 1'b1;
                res.slot  = to_slot_field(res_slot_reg);
                res.hit   = res_hit_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            victim_reg   <= '0;
            rd_idx_reg   <= '0;
            rd_done_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            victim_reg   <= victim_next;
            rd_idx_reg   <= rd_idx_next;
            rd_done_reg  <= rd_done_next;
            cmp_pend_reg <= cmp_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_slot_reg <= res_slot_next;
        res_hit_reg  <= res_hit_next;
    end

endmodule

// ===== hw/rtl/fifo_cache_directory_core.sv =====
// Timing: an accepted request scans the tag memory one slot a cycle; each slot's
// read data is registered and then compared with the item, and the scan ends at
// the hitting slot or, on a miss, after the last slot. A new request is taken only
// once its result has moved to the output register; a clear is taken in idle.
// Reset: all slots invalid, victim pointer at slot zero, tags left as they are.
// ----------------------------------------------------------------------------
// fifo_cache_directory_core
// Tag directory of a small fully associative cache with FIFO replacement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_cache_directory_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [15:0]          item_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fcd_pkg::slot_field_t slot,
    output logic                 hit
);
    import fcd_pkg::*;

    ram_req_t    ram_req;
    tag_t        ram_rdata;
    res_t        res;
    logic        res_take;

    logic        out_valid_reg, out_valid_next;
    slot_field_t slot_reg, slot_next;
    logic        hit_reg, hit_next;

    fcd_tag_ram u_tag_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    fcd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .item_number (item_number),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .res         (res),
        .res_take    (res_take)
    );

    // output register: loads when empty or being drained
    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            slot_next      = res.slot;
            hit_next       = res.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign hit       = hit_reg;

    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, res_take && out_valid_reg && !out_ready)
    `ASSERT_PROP(a_req_busy, clk, rst_n, (in_valid && in_ready && (mode == MODE_REQ)) |=> !in_ready)
    `ASSERT_PROP(a_clear_idle, clk, rst_n, (in_valid && in_ready && (mode == MODE_CLEAR)) |=> in_ready)
    `ASSERT_PROP(a_take_frees, clk, rst_n, res_take |=> in_ready)

endmodule

// ===== sim/fifo_cache_directory_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_cache_directory_checker
// Watches both channels of the cache directory, tracks tags, valid bits and
// the round-robin victim slot, and compares every result with the placement
// predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module fifo_cache_directory_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 mode,
    input  logic [15:0]          item_number,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  fcd_pkg::slot_field_t slot,
    input  logic                 hit,
    output int                   fail_count,
    output int                   pending
);
    import fcd_pkg::*;

    typedef struct {
        slot_field_t slot;
        logic        hit;
    } placement_t;

    tag_t         dir_tags  [SLOTS];
    logic         dir_valid [SLOTS];
    slot_idx_t    next_victim;
    placement_t   placements_q [$];

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        next_victim = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            dir_tags[k]  = '0;
            dir_valid[k] = 1'b0;
        end
    end

    function automatic slot_field_t to_slot_field_value(input slot_idx_t idx);
        return slot_field_t'(int'(idx) % 8);
    endfunction

    // Look the item up; on a miss it goes into the victim slot.
    function automatic placement_t place_item(input tag_t number);
        placement_t p;
        int         found;
        found = -1;
        for (int k = 0; k < SLOTS; k++)
            if (found < 0 && dir_valid[k] && dir_tags[k] == number)
                found = k;
        if (found >= 0)
        begin
            p.slot = slot_field_t'(found);
            p.hit  = 1'b1;
        end
        else
        begin
            dir_tags[next_victim]  = number;
            dir_valid[next_victim] = 1'b1;
            p.slot      = to_slot_field_value(next_victim);
            p.hit       = 1'b0;
            next_victim = (next_victim == LAST_IDX) ? '0 : next_victim + 1'b1;
        end
        return p;
    endfunction

    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n)
        begin
            // results first: a new request cannot complete in its own cycle
            if (out_valid && out_ready)
            begin
                if (placements_q.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding: slot %0d hit %0b",
                             $time, slot, hit);
                    fail_count++;
                end
                else
                begin
                    want = placements_q.pop_front();
                    if (slot !== want.slot)
                    begin
                        $display("%0t: slot mismatch: expected %0d, actual %0d",
                                 $time, want.slot, slot);
                        fail_count++;
                    end
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch: expected %0b, actual %0b",
                                 $time, want.hit, hit);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_CLEAR)
                begin
                    for (int k = 0; k < SLOTS; k++)
                        dir_valid[k] = 1'b0;
                    next_victim = '0;
                end
                else
                    placements_q.push_back(place_item(item_number));
            end
            pending = placements_q.size();
        end
    end

endmodule

// ===== sim/fifo_cache_directory_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_cache_directory_core_tb
// Drives requests and clears into the cache directory: a directed sequence
// covering fill, hits in several slots, eviction and clears, then random
// requests over a small working set under several idle and stall patterns,
// including one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module fifo_cache_directory_core_tb;
    import fcd_pkg::*;

    localparam int ITEMS_PER_PHASE = 245;
    localparam int LONG_HOLD       = 300;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        mode        = MODE_REQ;
    logic [15:0] item_number = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    slot_field_t slot;
    logic        hit;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic stall_hold     = 1'b0;
    event hold_off_ev;

    fifo_cache_directory_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .item_number (item_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot        (slot),
        .hit         (hit)
    );

    fifo_cache_directory_checker dir_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .item_number (item_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot        (slot),
        .hit         (hit),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= !stall_hold && ($urandom_range(0, 99) >= recv_stall_pct);

    // long output hold, counted here while the sender keeps offering items
    always
    begin
        @(hold_off_ev);
        stall_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        stall_hold <= 1'b0;
    end

    task automatic send_item(input logic req_mode, input tag_t number);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= req_mode;
        item_number <= number;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin
        tag_t working_set [16];
        int   set_size;
        int   roll;
        tag_t number;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill all eight slots, hit a few, then wrap the victim slot
        send_item(MODE_REQ, 16'h0000);
        send_item(MODE_REQ, 16'h0000);
        send_item(MODE_REQ, 16'hFFFF);
        send_item(MODE_REQ, 16'h5555);
        send_item(MODE_REQ, 16'hAAAA);
        send_item(MODE_REQ, 16'h0004);
        send_item(MODE_REQ, 16'h0005);
        send_item(MODE_REQ, 16'h0006);
        send_item(MODE_REQ, 16'h0007);
        send_item(MODE_REQ, 16'hFFFF);
        send_item(MODE_REQ, 16'h0007);
        send_item(MODE_REQ, 16'hAAAA);
        send_item(MODE_REQ, 16'h1234);
        send_item(MODE_REQ, 16'h0000);
        // clear keeps stale tags, which must no longer match
        send_item(MODE_CLEAR, 16'hFFFF);
        send_item(MODE_REQ, 16'h5555);
        send_item(MODE_REQ, 16'h5555);
        send_item(MODE_CLEAR, 16'h0000);
        send_item(MODE_CLEAR, 16'hA5A5);
        send_item(MODE_REQ, 16'h0001);
        send_item(MODE_REQ, 16'h8000);
        send_item(MODE_REQ, 16'h0001);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    -> hold_off_ev;
                end
            endcase
            // working set a bit smaller or larger than the directory
            set_size = $urandom_range(5, 16);
            for (int k = 0; k < 16; k++)
                working_set[k] = tag_t'($urandom);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    send_item(MODE_CLEAR, tag_t'($urandom));
                else if (roll < 13)
                    send_item(MODE_REQ, tag_t'($urandom));
                else
                begin
                    if ($urandom_range(0, 19) == 0)
                        working_set[$urandom_range(0, set_size - 1)] = tag_t'($urandom);
                    number = working_set[$urandom_range(0, set_size - 1)];
                    send_item(MODE_REQ, number);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SLOTS + 6) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
